/* src/ymodem_packet_receiver_top_assert.svh */
// Assertion macros used by the receiver back end.
// They expect signals named clk and rst_n in the module that uses them.
`ifndef YMODEM_PACKET_RECEIVER_TOP_ASSERT_SVH
`define YMODEM_PACKET_RECEIVER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define YMPR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define YMPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/ympr_pkg.sv */
package ympr_pkg;

    // Payload length of one data packet.
    localparam int PACKET_BYTES = 128;

    // Byte position counter saturates at PACKET_BYTES + 5.
    localparam int POS_MAX = PACKET_BYTES + 5;
    localparam int POS_W = $clog2(POS_MAX + 1);

    // Depth of the command queue between the front and back ends.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Frame types and reply bytes.
    localparam logic [7:0] FR_SOH = 8'h01;
    localparam logic [7:0] FR_EOT = 8'h04;
    localparam logic [7:0] RP_ACK = 8'h06;
    localparam logic [7:0] RP_NACK = 8'h15;
    localparam logic [7:0] RP_C = 8'h43;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_WRITE  = 3'd0,
        KIND_REPLY  = 3'd1,
        KIND_ERASE  = 3'd2,
        KIND_MARK   = 3'd3,
        KIND_RESET  = 3'd4,
        KIND_DONE   = 3'd5
    } kind_t;

    // Frame-end action sequences.
    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_DATA  = 3'd2,
        ACT_END   = 3'd3,
        ACT_EOT1  = 3'd4,
        ACT_EOT2  = 3'd5
    } act_t;

    // One queued command: an optional flash write, an optional frame-done
    // report and an action sequence.
    typedef struct packed {
        logic        has_write;
        logic [14:0] offset;
        logic [7:0]  wbyte;
        logic        has_done;
        logic        crc_ok;
        act_t        act;
    } ympr_cmd_t;

    // One action item: its kind and the reply byte for replies.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] reply;
    } act_item_t;

    // CRC-16/XMODEM update over one byte.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ 16'h1021;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // Number of results an action sequence produces.
    function automatic logic [2:0] act_len(input act_t act);
        logic [2:0] n;
        unique case (act)
            ACT_NONE:  n = 3'd0;
            ACT_START: n = 3'd3;
            ACT_DATA:  n = 3'd1;
            ACT_END:   n = 3'd2;
            ACT_EOT1:  n = 3'd1;
            ACT_EOT2:  n = 3'd3;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

    // Item idx of an action sequence.
    function automatic act_item_t act_item(input act_t act, input logic [1:0] idx);
        act_item_t it;
        it.kind = KIND_REPLY;
        it.reply = 8'h00;
        unique case (act)
            ACT_START:
            begin
                if (idx == 2'd0)
                begin
                    it.reply = RP_ACK;
                end
                else if (idx == 2'd1)
                begin
                    it.reply = RP_C;
                end
                else
                begin
                    it.kind = KIND_ERASE;
                end
            end
            ACT_DATA:
            begin
                it.reply = RP_ACK;
            end
            ACT_END:
            begin
                if (idx == 2'd0)
                begin
                    it.reply = RP_ACK;
                end
                else
                begin
                    it.kind = KIND_RESET;
                end
            end
            ACT_EOT1:
            begin
                it.reply = RP_NACK;
            end
            ACT_EOT2:
            begin
                if (idx == 2'd0)
                begin
                    it.reply = RP_ACK;
                end
                else if (idx == 2'd1)
                begin
                    it.reply = RP_C;
                end
                else
                begin
                    it.kind = KIND_MARK;
                end
            end
            default:
            begin
                it.kind = KIND_DONE;
            end
        endcase
        return it;
    endfunction

endpackage

/* src/ympr_front.sv */
module ympr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          rx_byte,
    input  logic                frame_last,
    input  logic                q_full,
    output logic                push,
    output ympr_pkg::ympr_cmd_t push_cmd
);
    import ympr_pkg::*;

    // Transfer phase, one-hot.
    typedef enum logic [3:0] {
        PH_START = 4'b0001,
        PH_DATA  = 4'b0010,
        PH_EOT2  = 4'b0100,
        PH_END   = 4'b1000
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [7:0]      pkt_cnt_reg, pkt_cnt_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]      ftype_reg, ftype_next;
    logic [7:0]      seq_reg, seq_next;
    logic            hsum_ok_reg, hsum_ok_next;
    logic [15:0]     crc_reg, crc_next;
    logic [15:0]     rcrc_reg, rcrc_next;
    logic            wr_en_reg, wr_en_next;

    logic            accept;
    logic [POS_W-1:0] pos_inc;
    logic [7:0]      pkt_minus;
    logic [14:0]     off_full;
    ympr_cmd_t       cmd;

    assign in_ready = !q_full;
    assign accept = in_valid && in_ready;

    // Image offset of the current payload byte.
    assign pkt_minus = pkt_cnt_reg - 8'd1;
    assign off_full = 15'(32'(pkt_minus) * 32'(PACKET_BYTES) + 32'(pos_reg) - 32'd3);

    // Byte decode, frame-end classification and next state.
    always_comb
    begin
        phase_next = phase_reg;
        pkt_cnt_next = pkt_cnt_reg;
        ftype_next = ftype_reg;
        seq_next = seq_reg;
        hsum_ok_next = hsum_ok_reg;
        crc_next = crc_reg;
        rcrc_next = rcrc_reg;
        wr_en_next = wr_en_reg;
        cmd = '0;
        cmd.act = ACT_NONE;

        priority if (pos_reg == POS_W'(0))
        begin
            ftype_next = rx_byte;
        end
        else if (pos_reg == POS_W'(1))
        begin
            seq_next = rx_byte;
        end
        else if (pos_reg == POS_W'(2))
        begin
            hsum_ok_next = ({1'b0, seq_reg} + {1'b0, rx_byte}) == 9'd255;
            wr_en_next = hsum_ok_next && (ftype_reg == FR_SOH) && (phase_reg == PH_DATA);
        end
        else if (pos_reg <= POS_W'(PACKET_BYTES + 2))
        begin
            crc_next = crc_step(crc_reg, rx_byte);
            cmd.has_write = wr_en_reg;
            cmd.offset = off_full;
            cmd.wbyte = rx_byte;
        end
        else if (pos_reg == POS_W'(PACKET_BYTES + 3))
        begin
            rcrc_next = {rx_byte, 8'h00};
        end
        else if (pos_reg == POS_W'(PACKET_BYTES + 4))
        begin
            rcrc_next = {rcrc_reg[15:8], rx_byte};
        end
        else
        begin
            // Bytes past the CRC field are ignored.
            rcrc_next = rcrc_reg;
        end

        pos_inc = (pos_reg < POS_W'(POS_MAX)) ? pos_reg + POS_W'(1) : pos_reg;
        pos_next = pos_inc;

        if (frame_last)
        begin
            cmd.has_done = 1'b1;
            cmd.crc_ok = (ftype_next == FR_SOH) && (pos_inc == POS_W'(POS_MAX)) &&
                         (crc_next == rcrc_next);
            if ((ftype_next == FR_SOH) && hsum_ok_next)
            begin
                if ((phase_reg == PH_START) && (seq_next == 8'd0))
                begin
                    cmd.act = ACT_START;
                    phase_next = PH_DATA;
                    pkt_cnt_next = 8'd1;
                end
                else if (phase_reg == PH_DATA)
                begin
                    cmd.act = ACT_DATA;
                    pkt_cnt_next = pkt_cnt_reg + 8'd1;
                end
                else if (phase_reg == PH_END)
                begin
                    cmd.act = ACT_END;
                    phase_next = PH_START;
                    pkt_cnt_next = 8'd0;
                end
            end
            else if (ftype_next == FR_EOT)
            begin
                if (phase_reg == PH_DATA)
                begin
                    cmd.act = ACT_EOT1;
                    phase_next = PH_EOT2;
                end
                else if (phase_reg == PH_EOT2)
                begin
                    cmd.act = ACT_EOT2;
                    phase_next = PH_END;
                end
            end
            // Every frame end clears the per-frame state.
            pos_next = '0;
            ftype_next = 8'd0;
            seq_next = 8'd0;
            hsum_ok_next = 1'b0;
            crc_next = 16'd0;
            rcrc_next = 16'd0;
            wr_en_next = 1'b0;
        end
    end

    assign push = accept && (cmd.has_write || cmd.has_done);
    assign push_cmd = cmd;

    // State registers, updated on each accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            pkt_cnt_reg <= 8'd0;
            pos_reg <= '0;
            ftype_reg <= 8'd0;
            seq_reg <= 8'd0;
            hsum_ok_reg <= 1'b0;
            crc_reg <= 16'd0;
            rcrc_reg <= 16'd0;
            wr_en_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pkt_cnt_reg <= pkt_cnt_next;
            pos_reg <= pos_next;
            ftype_reg <= ftype_next;
            seq_reg <= seq_next;
            hsum_ok_reg <= hsum_ok_next;
            crc_reg <= crc_next;
            rcrc_reg <= rcrc_next;
            wr_en_reg <= wr_en_next;
        end
    end

endmodule

/* src/ympr_queue.sv */
module ympr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ympr_pkg::ympr_cmd_t push_cmd,
    output logic                full,
    input  logic                pop,
    output ympr_pkg::ympr_cmd_t head_cmd,
    output logic                empty
);
    import ympr_pkg::*;

    ympr_cmd_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head_cmd = entry_reg[rptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

/* src/ympr_back.sv */
`include "ymodem_packet_receiver_top_assert.svh"

module ympr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ympr_pkg::ympr_cmd_t head_cmd,
    input  logic                empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          kind,
    output logic [14:0]         write_offset,
    output logic [7:0]          write_byte,
    output logic [7:0]          reply_byte,
    output logic                crc_ok,
    output logic                last_result
);
    import ympr_pkg::*;

    logic [2:0]  step_reg, step_next;
    logic        out_valid_reg, out_valid_next;
    kind_t       kind_reg;
    logic [14:0] offset_reg;
    logic [7:0]  wbyte_reg;
    logic [7:0]  reply_reg;
    logic        crc_ok_reg;
    logic        last_reg;

    logic        advance;
    logic [2:0]  n_res;
    logic [2:0]  j;
    logic [1:0]  item_idx;
    act_item_t   item;
    kind_t       res_kind;
    logic [14:0] res_offset;
    logic [7:0]  res_wbyte;
    logic [7:0]  res_reply;
    logic        res_crc_ok;
    logic        res_last;

    // Select the result at the current step of the head command.
    assign n_res = {2'b00, head_cmd.has_write} + {2'b00, head_cmd.has_done} +
                   act_len(head_cmd.act);
    assign j = step_reg - {2'b00, head_cmd.has_write};
    assign item_idx = 2'(j - 3'd1);
    assign item = act_item(head_cmd.act, item_idx);

    always_comb
    begin
        res_kind = KIND_DONE;
        res_offset = 15'd0;
        res_wbyte = 8'd0;
        res_reply = 8'd0;
        res_crc_ok = 1'b0;
        if (head_cmd.has_write && (step_reg == 3'd0))
        begin
            res_kind = KIND_WRITE;
            res_offset = head_cmd.offset;
            res_wbyte = head_cmd.wbyte;
        end
        else if (j == 3'd0)
        begin
            res_kind = KIND_DONE;
            res_crc_ok = head_cmd.crc_ok;
        end
        else
        begin
            res_kind = item.kind;
            res_reply = item.reply;
        end
    end

    assign res_last = (step_reg == n_res - 3'd1);
    assign advance = !empty && (!out_valid_reg || out_ready);
    assign pop = advance && res_last;

    // Step counter and output valid.
    always_comb
    begin
        step_next = step_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            step_next = res_last ? 3'd0 : step_reg + 3'd1;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            kind_reg <= res_kind;
            offset_reg <= res_offset;
            wbyte_reg <= res_wbyte;
            reply_reg <= res_reply;
            crc_ok_reg <= res_crc_ok;
            last_reg <= res_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind = kind_reg;
    assign write_offset = offset_reg;
    assign write_byte = wbyte_reg;
    assign reply_byte = reply_reg;
    assign crc_ok = crc_ok_reg;
    assign last_result = last_reg;

    `YMPR_ASSERT_SAME(a_step_in_range, !empty, step_reg < n_res, "step past end of command")
    `YMPR_ASSERT_NEXT(a_step_restart, pop, step_reg == 3'd0, "step not cleared after pop")
    `YMPR_ASSERT_SAME(a_offset_only_write, out_valid_reg && (kind_reg != KIND_WRITE),
        (offset_reg == 15'd0) && (wbyte_reg == 8'd0), "write fields set on non-write word")
    `YMPR_ASSERT_SAME(a_crc_only_done, out_valid_reg && crc_ok_reg, kind_reg == KIND_DONE,
        "crc_ok set on a word other than frame done")

endmodule

/* src/ymodem_packet_receiver_top.sv */
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tdata: rx_byte; tlast: frame_last
// m_*      out  m_tvalid/m_tready  tdata: write_offset, write_byte, reply_byte,
//                                  crc_ok; tuser: kind; tlast: last_result
//
// One received byte is accepted per cycle while the command queue has room.
// Each byte yields zero to four output words; the back end emits one word per
// cycle unless m_tready stalls it, so a frame end may leave up to four words.
// The four-entry command queue lets input continue while those words drain.
// Reset (rst_n low, asynchronous) returns the transfer to the start phase.
// A stalled output holds its word in the output register while input proceeds.
module ymodem_packet_receiver_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [14:0] write_offset, [22:15] write_byte,
                                   // [30:23] reply_byte, [31] crc_ok
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast
);
    import ympr_pkg::*;

    logic        push;
    ympr_cmd_t   push_cmd;
    logic        q_full;
    logic        pop;
    ympr_cmd_t   head_cmd;
    logic        q_empty;
    logic [14:0] write_offset;
    logic [7:0]  write_byte;
    logic [7:0]  reply_byte;
    logic        crc_ok;

    // Front end: decodes bytes and classifies frames.
    ympr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .rx_byte    (s_tdata),
        .frame_last (s_tlast),
        .q_full     (q_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // Command queue between the two ends.
    ympr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (q_empty)
    );

    // Back end: expands commands into output words.
    ympr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_cmd     (head_cmd),
        .empty        (q_empty),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .kind         (m_tuser),
        .write_offset (write_offset),
        .write_byte   (write_byte),
        .reply_byte   (reply_byte),
        .crc_ok       (crc_ok),
        .last_result  (m_tlast)
    );

    assign m_tdata = {crc_ok, reply_byte, write_byte, write_offset};

endmodule
